// File: rtl/tce_pkg.sv
// Package for the text console engine: field widths, operation and character
// codes, controller states and the command and status bundles.
// No dependencies.
package tce_pkg;

	// Default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Field widths fixed by the stream format
	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 4;
	localparam int STYLE_W  = 8;
	localparam int INDEX_W  = 11;
	localparam int CURSOR_W = 11;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Interpreted character codes
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Spaces written by a tab before its extra skip
	localparam int TAB_SPACES = 4;
	localparam int TAB_W      = 3;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_PUT,
		S_NEWLINE,
		S_RETURN,
		S_BACKSPACE,
		S_TAB,
		S_SCROLL,
		S_BLANK,
		S_CLEAR,
		S_READ,
		S_READ_CAP,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_INIT_WR,
		ACT_CLEAR_WR,
		ACT_PUT,
		ACT_TAB_STEP,
		ACT_NEWLINE,
		ACT_RETURN,
		ACT_BACKSPACE,
		ACT_SCROLL_MOVE,
		ACT_BLANK_WR,
		ACT_READ_ISSUE,
		ACT_READ_CAP
	} act_t;

	typedef struct packed {
		act_t act;
		logic load_item;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic wrap;
		logic last_row;
		logic cnt_at_last;
		logic cnt_at_end;
		logic is_tab;
		logic tab_last;
		logic tab_fin;
		logic out_free;
	} status_t;

endpackage

// File: rtl/text_console_engine_top.sv
// Text console engine: a COLUMNS x ROWS screen of character and style cells
// with a cursor, driven by one stream of put, clear and read transactions and
// answering each with one result. A step that scrolls and a clear both sweep
// the cell memories one cell per cycle through their single write port. After
// reset the block zeroes the screen with s_axis_tready low. A finished result
// waits in an output register while the next transaction is taken.
// Depends on tce_pkg, tce_ctrl, tce_datapath and tce_ram.
module text_console_engine_top
	import tce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// character [7:0], foreground [11:8], background [15:12], cell_index [26:16]
	input  logic [31:0] s_axis_tdata,
	// op [1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// cursor [10:0], scrolled [11], read_character [19:12], read_style [27:20]
	output logic [31:0] m_axis_tdata
);

	localparam int Extent = COLUMNS * ROWS;

	cmd_t                cmd;
	status_t             status;
	logic [CURSOR_W-1:0] cursor;
	logic                scrolled;
	logic [CHAR_W-1:0]   read_character;
	logic [STYLE_W-1:0]  read_style;

	tce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.op       (s_axis_tuser),
		.character(s_axis_tdata[7:0]),
		.status   (status),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	tce_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.op            (s_axis_tuser),
		.character     (s_axis_tdata[7:0]),
		.foreground    (s_axis_tdata[11:8]),
		.background    (s_axis_tdata[15:12]),
		.cell_index    (s_axis_tdata[26:16]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.cursor        (cursor),
		.scrolled      (scrolled),
		.read_character(read_character),
		.read_style    (read_style)
	);

	// Pack the result
	assign m_axis_tdata = {4'b0, read_style, read_character, scrolled, cursor};

`ifndef NO_ASSERTIONS
	// The datapath stays quiet whenever a new transaction can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (cmd.act == ACT_NONE))
		else $error("datapath busy while taking a transaction");

	// Only a put scrolls, and a put reads nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && scrolled) |-> (read_character == '0 && read_style == '0))
		else $error("scrolled result carries read data");

	// The reported cursor lies on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(cursor) < 32'(Extent)))
		else $error("cursor off the screen");

	// A result is loaded only when the previous one has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !cmd.load_out)
		else $error("result overwritten before transaction");
`endif

endmodule

// File: rtl/tce_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module tce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tce_ctrl.sv
// Controller of the text console engine: sequences each transaction through
// the datapath. Depends on tce_pkg.
module tce_ctrl
	import tce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [OP_W-1:0]   op,
	input  logic [CHAR_W-1:0] character,
	input  status_t           status,
	output logic              in_ready,
	output cmd_t              cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	// Pick the first working state for a new item
	function automatic state_t dispatch(input logic [OP_W-1:0] o, input logic [CHAR_W-1:0] c);
		state_t s;
		s = S_DONE;
		unique case (o)
			OP_PUT: begin
				unique case (c)
					CH_NEWLINE:   s = S_NEWLINE;
					CH_RETURN:    s = S_RETURN;
					CH_BACKSPACE: s = S_BACKSPACE;
					CH_TAB:       s = S_TAB;
					default:      s = S_PUT;
				endcase
			end
			OP_CLEAR: s = S_CLEAR;
			OP_READ:  s = S_READ;
			default:  s = S_DONE;
		endcase
		return s;
	endfunction

	assign accept = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (status.cnt_at_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = dispatch(op, character);
			end
			S_PUT: begin
				state_d = status.wrap ? S_SCROLL : S_DONE;
			end
			S_NEWLINE: begin
				state_d = status.last_row ? S_SCROLL : S_DONE;
			end
			S_RETURN, S_BACKSPACE, S_READ_CAP: begin
				state_d = S_DONE;
			end
			S_TAB: begin
				if (status.wrap) state_d = S_SCROLL;
				else if (status.tab_last) state_d = S_DONE;
			end
			S_SCROLL: begin
				if (status.cnt_at_last) state_d = S_BLANK;
			end
			S_BLANK: begin
				if (status.cnt_at_end) begin
					state_d = (status.is_tab && !status.tab_fin) ? S_TAB : S_DONE;
				end
			end
			S_CLEAR: begin
				if (status.cnt_at_end) state_d = S_DONE;
			end
			S_READ: begin
				state_d = S_READ_CAP;
			end
			S_DONE: begin
				if (status.out_free) begin
					state_d = accept ? dispatch(op, character) : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd.act       = ACT_NONE;
		cmd.load_item = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			S_INIT:      cmd.act = ACT_INIT_WR;
			S_IDLE:      in_ready = 1'b1;
			S_PUT:       cmd.act = ACT_PUT;
			S_NEWLINE:   cmd.act = ACT_NEWLINE;
			S_RETURN:    cmd.act = ACT_RETURN;
			S_BACKSPACE: cmd.act = ACT_BACKSPACE;
			S_TAB:       cmd.act = ACT_TAB_STEP;
			S_SCROLL:    cmd.act = ACT_SCROLL_MOVE;
			S_BLANK:     cmd.act = ACT_BLANK_WR;
			S_CLEAR:     cmd.act = ACT_CLEAR_WR;
			S_READ:      cmd.act = ACT_READ_ISSUE;
			S_READ_CAP:  cmd.act = ACT_READ_CAP;
			S_DONE: begin
				in_ready     = status.out_free;
				cmd.load_out = status.out_free;
			end
			default:     cmd.act = ACT_NONE;
		endcase
		cmd.load_item = in_valid && in_ready;
	end

endmodule

// File: rtl/tce_datapath.sv
// Datapath of the text console engine: cursor, sweep counter, cell memories
// and the result register. Depends on tce_pkg and tce_ram.
module tce_datapath
	import tce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [OP_W-1:0]     op,
	input  logic [CHAR_W-1:0]   character,
	input  logic [COLOR_W-1:0]  foreground,
	input  logic [COLOR_W-1:0]  background,
	input  logic [INDEX_W-1:0]  cell_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CURSOR_W-1:0] cursor,
	output logic                scrolled,
	output logic [CHAR_W-1:0]   read_character,
	output logic [STYLE_W-1:0]  read_style
);

	localparam int Extent = COLUMNS * ROWS;
	localparam int AW     = $clog2(Extent);
	localparam int CW     = $clog2(COLUMNS);
	localparam int RW     = $clog2(ROWS);

	localparam logic [AW-1:0] LastCell     = AW'(Extent - 1);
	localparam logic [AW-1:0] LastRowStart = AW'(Extent - COLUMNS);
	localparam logic [AW-1:0] ColsA        = AW'(COLUMNS);
	localparam logic [CW-1:0] ColMax       = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] RowMax       = RW'(ROWS - 1);

	// Control registers
	logic [AW-1:0]    cursor_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [AW-1:0]    cnt_q;
	logic [TAB_W-1:0] tab_q;
	logic             scrolled_q;
	logic             mv_vld_s1;
	logic             out_vld_q;

	// Item and result payload
	logic [CHAR_W-1:0]   char_q;
	logic [STYLE_W-1:0]  style_q;
	logic [AW-1:0]       idx_q;
	logic                idx_ok_q;
	logic                is_tab_q;
	logic [CHAR_W-1:0]   rd_char_q;
	logic [STYLE_W-1:0]  rd_style_q;
	logic [AW-1:0]       mv_addr_s1;
	logic [CURSOR_W-1:0] out_cursor_q;
	logic                out_scrolled_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic [STYLE_W-1:0]  out_style_q;

	// Next cursor values
	logic [AW-1:0] cursor_d;
	logic [RW-1:0] row_d;
	logic [CW-1:0] col_d;
	logic          start_scroll;
	logic          advance;
	logic          tab_put;
	logic [AW-1:0] back_pos;

	// Memory ports
	logic              char_we;
	logic              style_we;
	logic [AW-1:0]     waddr;
	logic [CHAR_W-1:0] char_wdata;
	logic [STYLE_W-1:0] style_wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [CHAR_W-1:0] char_rdata;
	logic [STYLE_W-1:0] style_rdata;

	assign tab_put  = tab_q < TAB_W'(TAB_SPACES);
	assign back_pos = (cursor_q != '0) ? cursor_q - AW'(1) : '0;

	// Status toward the controller
	assign status.wrap        = cursor_q == LastCell;
	assign status.last_row    = row_q == RowMax;
	assign status.cnt_at_last = cnt_q == LastRowStart;
	assign status.cnt_at_end  = cnt_q == LastCell;
	assign status.is_tab      = is_tab_q;
	assign status.tab_last    = tab_q == TAB_W'(TAB_SPACES);
	assign status.tab_fin     = tab_q == TAB_W'(TAB_SPACES + 1);
	assign status.out_free    = !out_vld_q || out_ready;

	// Cursor movement
	always_comb begin
		cursor_d     = cursor_q;
		row_d        = row_q;
		col_d        = col_q;
		start_scroll = 1'b0;
		advance      = 1'b0;
		unique case (cmd.act)
			ACT_PUT, ACT_TAB_STEP: advance = 1'b1;
			ACT_NEWLINE: begin
				if (row_q == RowMax) begin
					start_scroll = 1'b1;
				end else begin
					cursor_d = cursor_q - AW'(col_q) + ColsA;
					row_d    = row_q + RW'(1);
					col_d    = '0;
				end
			end
			ACT_RETURN: begin
				cursor_d = cursor_q - AW'(col_q);
				col_d    = '0;
			end
			ACT_BACKSPACE: begin
				cursor_d = back_pos;
				if (cursor_q != '0) begin
					if (col_q == '0) begin
						col_d = ColMax;
						row_d = row_q - RW'(1);
					end else begin
						col_d = col_q - CW'(1);
					end
				end
			end
			default: advance = 1'b0;
		endcase
		if (advance) begin
			if (cursor_q == LastCell) begin
				start_scroll = 1'b1;
			end else begin
				cursor_d = cursor_q + AW'(1);
				if (col_q == ColMax) begin
					col_d = '0;
					row_d = row_q + RW'(1);
				end else begin
					col_d = col_q + CW'(1);
				end
			end
		end
		if (start_scroll) begin
			cursor_d = LastRowStart;
			row_d    = RowMax;
			col_d    = '0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			row_q      <= '0;
			col_q      <= '0;
			cnt_q      <= '0;
			tab_q      <= '0;
			scrolled_q <= 1'b0;
			mv_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			cursor_q  <= cursor_d;
			row_q     <= row_d;
			col_q     <= col_d;
			mv_vld_s1 <= (cmd.act == ACT_SCROLL_MOVE) && (cnt_q != LastRowStart);
			// Sweep counter
			if (cmd.load_item || start_scroll) begin
				cnt_q <= '0;
			end else if (cmd.act == ACT_INIT_WR || cmd.act == ACT_CLEAR_WR
					|| cmd.act == ACT_BLANK_WR) begin
				cnt_q <= (cnt_q == LastCell) ? '0 : cnt_q + AW'(1);
			end else if (cmd.act == ACT_SCROLL_MOVE && cnt_q != LastRowStart) begin
				cnt_q <= cnt_q + AW'(1);
			end
			// Tab step count
			if (cmd.load_item) begin
				tab_q <= '0;
			end else if (cmd.act == ACT_TAB_STEP) begin
				tab_q <= tab_q + TAB_W'(1);
			end
			if (cmd.load_item) begin
				scrolled_q <= 1'b0;
			end else if (start_scroll) begin
				scrolled_q <= 1'b1;
			end
			// Result valid
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		mv_addr_s1 <= cnt_q;
		if (cmd.load_item) begin
			char_q     <= character;
			style_q    <= {background, foreground};
			idx_q      <= AW'(cell_index);
			idx_ok_q   <= 32'(cell_index) < 32'(Extent);
			is_tab_q   <= (op == OP_PUT) && (character == CH_TAB);
			rd_char_q  <= '0;
			rd_style_q <= '0;
		end else if (cmd.act == ACT_READ_CAP && idx_ok_q) begin
			rd_char_q  <= char_rdata;
			rd_style_q <= style_rdata;
		end
		if (cmd.load_out) begin
			out_cursor_q   <= CURSOR_W'(cursor_q);
			out_scrolled_q <= scrolled_q;
			out_char_q     <= rd_char_q;
			out_style_q    <= rd_style_q;
		end
	end

	// Memory write port: row moves drain ahead of any other write
	always_comb begin
		char_we     = 1'b0;
		style_we    = 1'b0;
		waddr       = cnt_q;
		char_wdata  = CH_SPACE;
		style_wdata = style_q;
		if (mv_vld_s1) begin
			char_we     = 1'b1;
			style_we    = 1'b1;
			waddr       = mv_addr_s1;
			char_wdata  = char_rdata;
			style_wdata = style_rdata;
		end else begin
			unique case (cmd.act)
				ACT_INIT_WR: begin
					char_we     = 1'b1;
					style_we    = 1'b1;
					char_wdata  = '0;
					style_wdata = '0;
				end
				ACT_CLEAR_WR: begin
					char_we  = 1'b1;
					style_we = 1'b1;
				end
				ACT_BLANK_WR: begin
					char_we = 1'b1;
				end
				ACT_PUT: begin
					char_we    = 1'b1;
					style_we   = 1'b1;
					waddr      = cursor_q;
					char_wdata = char_q;
				end
				ACT_TAB_STEP: begin
					char_we  = tab_put;
					style_we = tab_put;
					waddr    = cursor_q;
				end
				ACT_BACKSPACE: begin
					char_we  = 1'b1;
					style_we = 1'b1;
					waddr    = back_pos;
				end
				default: begin
					char_we  = 1'b0;
					style_we = 1'b0;
				end
			endcase
		end
	end

	// Memory read port
	always_comb begin
		re    = 1'b0;
		raddr = idx_q;
		if (cmd.act == ACT_SCROLL_MOVE) begin
			re    = cnt_q != LastRowStart;
			raddr = cnt_q + ColsA;
		end else if (cmd.act == ACT_READ_ISSUE) begin
			re = idx_ok_q;
		end
	end

	tce_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(Extent)
	) u_char_ram (
		.clk  (clk),
		.we   (char_we),
		.waddr(waddr),
		.wdata(char_wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(char_rdata)
	);

	tce_ram #(
		.WIDTH(STYLE_W),
		.DEPTH(Extent)
	) u_style_ram (
		.clk  (clk),
		.we   (style_we),
		.waddr(waddr),
		.wdata(style_wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(style_rdata)
	);

	assign out_valid      = out_vld_q;
	assign cursor         = out_cursor_q;
	assign scrolled       = out_scrolled_q;
	assign read_character = out_char_q;
	assign read_style     = out_style_q;

endmodule
